// File: hdl/bvro_pkg.sv
// ----------------------------------------------------------------------------
// bvro_pkg
// Types and constants shared by the bit vector range operation block.
// ----------------------------------------------------------------------------
package bvro_pkg;

    localparam int NUM_BITS_DEF  = 4096;
    localparam int WORD_BITS_DEF = 32;
    localparam int SLICE_BITS    = 8;
    localparam int IDX_W         = 12;
    localparam int ANSWER_W      = 13;

    typedef enum logic [2:0] {
        ACT_CLEAR = 3'd0,
        ACT_SET   = 3'd1,
        ACT_FLIP  = 3'd2,
        ACT_COUNT = 3'd3,
        ACT_RUN   = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [IDX_W-1:0] left_index;
        logic [IDX_W-1:0] right_index;
    } req_t;

    typedef struct packed {
        logic [ANSWER_W-1:0] answer;
        logic                bad_range;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_WORK,
        ST_DONE
    } state_t;

endpackage

// File: hdl/bit_vector_range_ops.sv
// A good range is worked word by word: each word is read (ST_READ), waited
// on (ST_WAIT) and then worked one 8-bit slice per cycle (ST_WORK).
// A rejected range goes straight to ST_DONE. One request is in work at a time.
// After reset the block runs a clearing pass that zeroes every word of the
// word memory before it accepts its first request.
// Reset: aresetn, synchronous, active low.
// ----------------------------------------------------------------------------
// bit_vector_range_ops
// Word-serial range clear/set/flip, ones count and longest ones run.
// ----------------------------------------------------------------------------
module bit_vector_range_ops
    import bvro_pkg::*;
#(
    parameter int NUM_BITS  = NUM_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int NUM_WORDS  = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int PW         = AW + BW;
    localparam int NUM_SLICES = WORD_BITS / SLICE_BITS;
    localparam int SW         = (NUM_SLICES > 1) ? $clog2(NUM_SLICES) : 1;
    localparam int CW         = $clog2(SLICE_BITS + 1);

    state_t state_reg, state_next;
    logic             clr_reg, clr_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [SW-1:0]    slice_reg, slice_next;
    logic [AW-1:0]    last_reg;
    logic [BW-1:0]    lbit_reg, rbit_reg;
    logic [2:0]       act_reg;
    logic [ANSWER_W-1:0] ans_reg, ans_next, run_reg, run_next;
    logic             bad_reg;
    logic [AW-1:0]    first_reg;

    logic             we;
    logic [WORD_BITS-1:0] wdata, rdata, mask;
    logic [SLICE_BITS-1:0] sbits, smask;
    logic             last_slice;
    logic [PW-1:0]    lpos, rpos;
    logic             bad_in;

    // position split of the incoming range
    assign lpos   = PW'(s_data.left_index);
    assign rpos   = PW'(s_data.right_index);
    assign bad_in = (s_data.left_index > s_data.right_index) ||
                    (32'(s_data.right_index) >= NUM_BITS);

    assign last_slice = (slice_reg == SW'(NUM_SLICES - 1));

    bvro_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .addr  (addr_reg),
        .wdata (wdata),
        .rdata (rdata)
    );

    // range mask within the current word
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = ((addr_reg != first_reg) || (BW'(b) >= lbit_reg)) &&
                      ((addr_reg != last_reg)  || (BW'(b) <= rbit_reg));
        end
    end

    // word update value
    always_comb begin
        unique case (act_reg)
            ACT_CLEAR: wdata = rdata & ~mask;
            ACT_SET:   wdata = rdata | mask;
            ACT_FLIP:  wdata = rdata ^ mask;
            default:   wdata = rdata;
        endcase
        if (clr_reg) begin
            wdata = '0;
        end
    end

    // pick the slice of the word in work this cycle
    always_comb begin
        sbits = rdata[int'(slice_reg) * SLICE_BITS +: SLICE_BITS];
        smask = mask[int'(slice_reg) * SLICE_BITS +: SLICE_BITS];
    end

    // count and run over one slice
    logic [CW-1:0]       pop;
    logic [ANSWER_W-1:0] run_w, best_w;
    always_comb begin
        pop    = '0;
        run_w  = run_reg;
        best_w = ans_reg;
        for (int b = 0; b < SLICE_BITS; b++) begin
            if (smask[b]) begin
                pop = pop + CW'(sbits[b]);
                if (sbits[b]) begin
                    run_w = run_w + 1'b1;
                    if (run_w > best_w) begin
                        best_w = run_w;
                    end
                end else begin
                    run_w = '0;
                end
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (clr_reg) begin
                if (addr_reg == AW'(NUM_WORDS - 1)) state_next = ST_IDLE;
            end else if (s_valid) begin
                state_next = bad_in ? ST_DONE : ST_READ;
            end
            ST_READ: state_next = ST_WAIT;
            ST_WAIT: state_next = ST_WORK;
            ST_WORK: if (last_slice) begin
                state_next = (addr_reg == last_reg) ? ST_DONE : ST_READ;
            end
            ST_DONE: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        s_ready   = (state_reg == ST_IDLE) && !clr_reg;
        m_valid   = (state_reg == ST_DONE);
        m_data.answer    = ans_reg;
        m_data.bad_range = bad_reg;
        we        = clr_reg ||
                    ((state_reg == ST_WORK) && last_slice &&
                     (act_reg <= 3'(ACT_FLIP)));
        clr_next   = clr_reg && (addr_reg != AW'(NUM_WORDS - 1));
        addr_next  = addr_reg;
        slice_next = '0;
        ans_next   = ans_reg;
        run_next   = run_reg;
        if (clr_reg) begin
            addr_next = addr_reg + 1'b1;
        end else if (state_reg == ST_IDLE && s_valid) begin
            addr_next = lpos[PW-1:BW];
            ans_next  = '0;
            run_next  = '0;
        end else if (state_reg == ST_WORK) begin
            if (act_reg == 3'(ACT_COUNT)) begin
                ans_next = ans_reg + ANSWER_W'(pop);
            end else if (act_reg == 3'(ACT_RUN)) begin
                ans_next = best_w;
                run_next = run_w;
            end
            // advance the slice, then the word after the last slice
            if (!last_slice) begin
                slice_next = slice_reg + 1'b1;
            end else if (addr_reg != last_reg) begin
                addr_next = addr_reg + 1'b1;
            end
        end
    end

    // hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clr_reg   <= 1'b1;
            addr_reg  <= '0;
            slice_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            addr_reg  <= addr_next;
            slice_reg <= slice_next;
        end
    end

    // latch request fields; update answer and run
    always_ff @(posedge aclk) begin
        ans_reg <= ans_next;
        run_reg <= run_next;
        if (s_ready && s_valid) begin
            act_reg   <= s_data.action;
            bad_reg   <= bad_in;
            first_reg <= lpos[PW-1:BW];
            last_reg  <= rpos[PW-1:BW];
            lbit_reg  <= lpos[BW-1:0];
            rbit_reg  <= rpos[BW-1:0];
        end
    end

endmodule

// File: hdl/bvro_ram.sv
// ----------------------------------------------------------------------------
// bvro_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bvro_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, and register the read of the word as it was before the write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
